// File: design/fupe_pkg.sv
// ----------------------------------------------------------------------------
// fupe_pkg: shared types and constants of the form-url percent encoder
// queue entry layout, item kinds and the character helpers
// ----------------------------------------------------------------------------
package fupe_pkg;

  // item kinds decided by the front end
  localparam logic [1:0] KIND_PASS = 2'd0;  // one character, already mapped
  localparam logic [1:0] KIND_ESC  = 2'd1;  // '%' and two hex digits
  localparam logic [1:0] KIND_NL   = 2'd2;  // line feed, six characters

  // run lengths less one, as last character index
  localparam logic [2:0] ESC_LAST_IDX = 3'd2;
  localparam logic [2:0] NL_LAST_IDX  = 3'd5;

  // fixed characters
  localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // one classified transaction waiting for the back end
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] text;
  } entry_t;

  // queue status seen by both ends
  typedef struct packed {
    logic not_empty;
    logic full;
  } q_status_t;

  // uppercase hex digit of one nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return 8'h30 + {4'h0, nib};
    end
    return 8'h37 + {4'h0, nib};
  endfunction

  // the line feed run "%0D%0A"
  function automatic logic [7:0] nl_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = CH_PCT;
      3'd1:    ch = 8'h30;
      3'd2:    ch = 8'h44;
      3'd3:    ch = CH_PCT;
      3'd4:    ch = 8'h30;
      3'd5:    ch = 8'h41;
      default: ch = CH_PCT;
    endcase
    return ch;
  endfunction

endpackage

// File: design/fupe_front.sv
// ----------------------------------------------------------------------------
// fupe_front: input classifier
// accepts text bytes, sorts them into pass, escape or line feed kinds and
// drops carriage returns
// ----------------------------------------------------------------------------
module fupe_front (
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_text_byte,
  input  fupe_pkg::q_status_t q_status,
  output logic                push,
  output fupe_pkg::entry_t    push_entry
);

  logic is_pass;
  logic accept;

  // letters, digits and the safe set
  always_comb begin
    is_pass = 1'b0;
    if ((in_text_byte >= 8'h41) && (in_text_byte <= 8'h5A)) begin
      is_pass = 1'b1;
    end
    if ((in_text_byte >= 8'h61) && (in_text_byte <= 8'h7A)) begin
      is_pass = 1'b1;
    end
    if ((in_text_byte >= 8'h30) && (in_text_byte <= 8'h39)) begin
      is_pass = 1'b1;
    end
    case (in_text_byte)
      8'h24, 8'h2D, 8'h2E, 8'h5F, 8'h21, 8'h2A, 8'h28, 8'h29, 8'h2C: is_pass = 1'b1;
      default: ;
    endcase
  end

  // build the queue entry, space folds into a single pass character
  always_comb begin
    push_entry.kind = fupe_pkg::KIND_ESC;
    push_entry.text = in_text_byte;
    if (is_pass) begin
      push_entry.kind = fupe_pkg::KIND_PASS;
    end else if (in_text_byte == fupe_pkg::CH_SPACE) begin
      push_entry.kind = fupe_pkg::KIND_PASS;
      push_entry.text = fupe_pkg::CH_PLUS;
    end else if (in_text_byte == fupe_pkg::CH_LF) begin
      push_entry.kind = fupe_pkg::KIND_NL;
    end
  end

  // handshake, carriage return is taken but never queued
  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;
  assign push     = accept && (in_text_byte != fupe_pkg::CH_CR);

endmodule

// File: design/fupe_queue.sv
// ----------------------------------------------------------------------------
// fupe_queue: small queue between classifier and emitter
// lets the front keep taking transactions while a long escape drains
// ----------------------------------------------------------------------------
module fupe_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  fupe_pkg::entry_t    push_entry,
  input  logic                pop,
  output fupe_pkg::entry_t    head_entry,
  output fupe_pkg::q_status_t q_status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  fupe_pkg::entry_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  assign head_entry         = mem[rd_ptr_r];
  assign q_status.not_empty = (count_r != '0);
  assign q_status.full      = (count_r == FULL_CNT);

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: design/fupe_back.sv
// ----------------------------------------------------------------------------
// fupe_back: character emitter
// walks each queued transaction one character per cycle, while out_stall
// is low, into the output register and marks the last character of its run
// ----------------------------------------------------------------------------
module fupe_back (
  input  logic                clk,
  input  logic                rst_n,
  input  fupe_pkg::entry_t    head_entry,
  input  fupe_pkg::q_status_t q_status,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_char,
  output logic                out_run_last
);

  logic [2:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] char_r, char_nxt;
  logic       last_r, last_nxt;
  logic       load;

  // output register may take a new character
  assign load = !valid_r || !out_stall;

  // character and end of run for the current index
  always_comb begin
    char_nxt = fupe_pkg::CH_PCT;
    last_nxt = 1'b0;
    unique case (head_entry.kind)
      fupe_pkg::KIND_PASS: begin
        char_nxt = head_entry.text;
        last_nxt = 1'b1;
      end
      fupe_pkg::KIND_ESC: begin
        if (idx_r == 3'd1) begin
          char_nxt = fupe_pkg::hex_char(head_entry.text[7:4]);
        end else if (idx_r != 3'd0) begin
          char_nxt = fupe_pkg::hex_char(head_entry.text[3:0]);
        end
        last_nxt = (idx_r == fupe_pkg::ESC_LAST_IDX);
      end
      fupe_pkg::KIND_NL: begin
        char_nxt = fupe_pkg::nl_char(idx_r);
        last_nxt = (idx_r == fupe_pkg::NL_LAST_IDX);
      end
      default: begin
        char_nxt = head_entry.text;
        last_nxt = 1'b1;
      end
    endcase
  end

  // sequencing over the run
  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    pop       = 1'b0;
    if (load) begin
      valid_nxt = q_status.not_empty;
      if (q_status.not_empty) begin
        if (last_nxt) begin
          pop     = 1'b1;
          idx_nxt = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= char_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid    = valid_r;
  assign out_char     = char_r;
  assign out_run_last = last_r;

endmodule

// File: design/form_url_percent_encoder.sv
// ----------------------------------------------------------------------------
// form_url_percent_encoder: form-url encoding of a byte stream
// classifier, queue and character emitter
// ----------------------------------------------------------------------------
// One text byte is taken per cycle while the queue has room; each gives a run
// of output characters at one per cycle: one for letters, digits, the safe
// set and space (as '+'), three for escaped bytes, six for a line feed and
// none for a carriage return. Output rate is one character per cycle while
// out_stall is low, set by the single output register; input stalls
// only when the QUEUE_DEPTH entry queue fills behind a long run or a
// stalled output. out_run_last marks the last character of each run.
module form_url_percent_encoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_text_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_run_last
);

  fupe_pkg::q_status_t q_status;
  fupe_pkg::entry_t    push_entry;
  fupe_pkg::entry_t    head_entry;
  logic                push;
  logic                pop;

  // classify incoming transactions
  fupe_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_text_byte (in_text_byte),
    .q_status     (q_status),
    .push         (push),
    .push_entry   (push_entry)
  );

  // decoupling queue
  fupe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_entry (head_entry),
    .q_status   (q_status)
  );

  // emit characters
  fupe_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_entry   (head_entry),
    .q_status     (q_status),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .out_run_last (out_run_last)
  );

endmodule
